/* hdl/hlsr_pkg.sv */
// ----------------------------------------------------------------------------
// hlsr_pkg
// Shared widths, reset values and register indexes for the half-lattice
// subcube remapper and its pipelined divider.
// ----------------------------------------------------------------------------
package hlsr_pkg;

	// Lattice shape.
	localparam int NUM_DIMS            = 4;
	localparam int COORD_W             = 6;
	localparam int HALF_W              = 6;
	localparam int DEF_MAX_HALF_EXTENT = 32;

	// Index and divisor widths.
	localparam int IDX_W = 24;
	localparam int DIV_W = 25;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;

	// Register reset values.
	localparam logic [HALF_W-1:0] HALF_RESET = 6'd8;
	localparam logic [DIV_W-1:0]  DIV_RESET  = 25'd4096;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_HALF_EXTENT_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_EXTENT_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_EXTENT_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_EXTENT_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SITES_PER_RANK = 3'd4;

endpackage

/* hdl/half_lattice_subcube_remap.sv */
// ----------------------------------------------------------------------------
// half_lattice_subcube_remap
// Maps four lattice coordinates to a subcube-ordered packed index, and
// splits that index into destination rank and local slot.
// ----------------------------------------------------------------------------
// A word runs through the index arithmetic stages and then through the
// one-bit-per-stage divider. Throughput: one word per cycle while out_ready
// is high; every stage hands on when the next frees up.
// Reset: arst_n clears all stage valid bits and loads the half extents with 8
// and sites per rank with 4096.
module half_lattice_subcube_remap import hlsr_pkg::*; #(
	parameter int MAX_HALF_EXTENT = DEF_MAX_HALF_EXTENT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_W-1:0]    coord_0,
	input  logic [COORD_W-1:0]    coord_1,
	input  logic [COORD_W-1:0]    coord_2,
	input  logic [COORD_W-1:0]    coord_3,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [IDX_W-1:0]      packed_index,
	output logic [IDX_W-1:0]      target_rank,
	output logic [IDX_W-1:0]      local_index
);

	// Part sizes need room for twice the largest half extent.
	localparam int SW = $clog2(2 * MAX_HALF_EXTENT + 1);
	localparam int CW = (SW > COORD_W) ? SW : COORD_W;
	localparam logic [CW-1:0] MAX_H = CW'(MAX_HALF_EXTENT);

	// Configuration registers.
	logic [HALF_W-1:0] half_q [NUM_DIMS];
	logic [DIV_W-1:0]  spr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIMS; i++) begin
				half_q[i] <= HALF_RESET;
			end
			spr_q <= DIV_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_HALF_EXTENT_0:  half_q[0] <= cfg_data[HALF_W-1:0];
				REG_HALF_EXTENT_1:  half_q[1] <= cfg_data[HALF_W-1:0];
				REG_HALF_EXTENT_2:  half_q[2] <= cfg_data[HALF_W-1:0];
				REG_HALF_EXTENT_3:  half_q[3] <= cfg_data[HALF_W-1:0];
				REG_SITES_PER_RANK: spr_q     <= cfg_data[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamped half extents and the low, high and full part sizes.
	logic [SW-1:0] lo_sz  [NUM_DIMS];
	logic [SW-1:0] hi_sz  [NUM_DIMS];
	logic [SW-1:0] ext_sz [NUM_DIMS];

	always_comb begin
		logic [CW-1:0] hx;
		logic [SW-1:0] hc;
		for (int mu = 0; mu < NUM_DIMS; mu++) begin
			hx = CW'(half_q[mu]);
			if (hx == '0) begin
				hc = SW'(1);
			end else if (hx > MAX_H) begin
				hc = SW'(MAX_H);
			end else begin
				hc = SW'(hx);
			end
			lo_sz[mu]  = hc + SW'(1);
			hi_sz[mu]  = hc - SW'(1);
			ext_sz[mu] = hc << 1;
		end
	end

	// Stage valids and the ready chain, back from the divider.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic div_ready;

	assign en_s5    = !v_s5 || div_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Stage 1: part bit and digit of each coordinate.
	logic [COORD_W-1:0]  crd [NUM_DIMS];
	logic [NUM_DIMS-1:0] hib_c;
	logic [COORD_W-1:0]  dg_c  [NUM_DIMS];
	logic [NUM_DIMS-1:0] hib_s1;
	logic [COORD_W-1:0]  dg_s1 [NUM_DIMS];

	assign crd[0] = coord_0;
	assign crd[1] = coord_1;
	assign crd[2] = coord_2;
	assign crd[3] = coord_3;

	always_comb begin
		for (int mu = 0; mu < NUM_DIMS; mu++) begin
			hib_c[mu] = (CW'(crd[mu]) >= CW'(lo_sz[mu]));
			dg_c[mu]  = hib_c[mu] ? COORD_W'(CW'(crd[mu]) - CW'(lo_sz[mu])) : crd[mu];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			hib_s1 <= hib_c;
			for (int mu = 0; mu < NUM_DIMS; mu++) begin
				dg_s1[mu] <= dg_c[mu];
			end
		end
	end

	// Stage 2: first products of the offset and of the lower-subcube volumes.
	logic [SW-1:0]       rdx_s1 [NUM_DIMS];
	logic [IDX_W-1:0]    o01_s2, o23_s2, r23_s2, e23_s2, m0_s2, m1_s2, m2_s2;
	logic [NUM_DIMS-1:0] hib_s2;

	always_comb begin
		for (int mu = 0; mu < NUM_DIMS; mu++) begin
			rdx_s1[mu] = hib_s1[mu] ? hi_sz[mu] : lo_sz[mu];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			o01_s2 <= IDX_W'(dg_s1[0]) * IDX_W'(rdx_s1[1]) + IDX_W'(dg_s1[1]);
			o23_s2 <= IDX_W'(dg_s1[2]) * IDX_W'(rdx_s1[3]) + IDX_W'(dg_s1[3]);
			r23_s2 <= IDX_W'(rdx_s1[2]) * IDX_W'(rdx_s1[3]);
			e23_s2 <= IDX_W'(ext_sz[2]) * IDX_W'(ext_sz[3]);
			m0_s2  <= hib_s1[0] ? IDX_W'(lo_sz[0]) * IDX_W'(ext_sz[1]) : '0;
			m1_s2  <= hib_s1[1] ? IDX_W'(rdx_s1[0]) * IDX_W'(lo_sz[1]) : '0;
			m2_s2  <= IDX_W'(rdx_s1[0]) * IDX_W'(rdx_s1[1]);
			hib_s2 <= hib_s1;
		end
	end

	// Stage 3: whole offset and the volumes below in dimensions 0 and 1.
	logic [IDX_W-1:0] t0_s3, t1_s3, q2_s3, q3_s3, off_s3;
	logic             hib3_s3;
	logic [SW-1:0]    rdx2_s2;

	assign rdx2_s2 = hib_s2[2] ? hi_sz[2] : lo_sz[2];

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			t0_s3   <= m0_s2 * e23_s2;
			t1_s3   <= m1_s2 * e23_s2;
			q2_s3   <= hib_s2[2] ? m2_s2 * IDX_W'(lo_sz[2]) : '0;
			q3_s3   <= m2_s2 * IDX_W'(rdx2_s2);
			off_s3  <= o01_s2 * r23_s2 + o23_s2;
			hib3_s3 <= hib_s2[3];
		end
	end

	// Stage 4: volumes below in dimensions 2 and 3, first partial sum.
	logic [IDX_W-1:0] t2_s4, t3_s4, sa_s4;

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			t2_s4 <= q2_s3 * IDX_W'(ext_sz[3]);
			t3_s4 <= hib3_s3 ? q3_s3 * IDX_W'(lo_sz[3]) : '0;
			sa_s4 <= t0_s3 + t1_s3 + off_s3;
		end
	end

	// Stage 5: packed index, wrapping at the index width.
	logic [IDX_W-1:0] pk_s5;

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			pk_s5 <= sa_s4 + t2_s4 + t3_s4;
		end
	end

	// Rank and local slot; a zero divisor gives all ones and the index back.
	hlsr_div #(
		.NUM_W (IDX_W),
		.DEN_W (DIV_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_ready  (div_ready),
		.numer     (pk_s5),
		.denom     (spr_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.numer_out (packed_index),
		.quotient  (target_rank),
		.remainder (local_index)
	);

`ifndef NO_ASSERTIONS
	// Input is held off only when the index stages are all full and stalled.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !div_ready))
		else $error("input refused with a free index stage");

	// With no sites per rank every word goes to the all-ones rank.
	a_zero_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && spr_q == '0) |-> (target_rank == '1 && local_index == packed_index))
		else $error("zero divisor result wrong");
`endif

endmodule

/* hdl/hlsr_div.sv */
// ----------------------------------------------------------------------------
// hlsr_div
// Pipelined restoring divider: one quotient bit per stage, a new word may
// enter in every cycle while out_ready is high, and each stage holds its word while the next is full and stalled.
// ----------------------------------------------------------------------------
module hlsr_div import hlsr_pkg::*; #(
	parameter int NUM_W = IDX_W,
	parameter int DEN_W = DIV_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [NUM_W-1:0] numer_out,
	output logic [NUM_W-1:0] quotient,
	output logic [NUM_W-1:0] remainder
);

	// Per-stage registers; stage k settles quotient bit NUM_W-1-k.
	logic             v_s   [NUM_W];
	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] quo_s [NUM_W];
	logic [NUM_W-1:0] num_s [NUM_W];
	logic [NUM_W:0]   en;
	logic [NUM_W-1:0] full;

	assign en[NUM_W] = out_ready;
	assign in_ready  = en[0];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		localparam logic [NUM_W-1:0] QBIT = NUM_W'(1) << (NUM_W - 1 - k);
		logic             v_prev;
		logic [DEN_W-1:0] rem_prev;
		logic [NUM_W-1:0] quo_prev;
		logic [NUM_W-1:0] num_prev;
		logic [DEN_W:0]   trial;
		logic             ge;

		// The first stage starts from a zero remainder.
		if (k == 0) begin : g_first
			assign v_prev   = in_valid;
			assign rem_prev = '0;
			assign quo_prev = '0;
			assign num_prev = numer;
		end else begin : g_next
			assign v_prev   = v_s[k-1];
			assign rem_prev = rem_s[k-1];
			assign quo_prev = quo_s[k-1];
			assign num_prev = num_s[k-1];
		end

		// A stage may load when empty or when its word moves on.
		assign en[k]   = !v_s[k] || en[k+1];
		assign full[k] = v_s[k];

		// Shift in the next numerator bit and try the subtraction.
		assign trial = {rem_prev, num_prev[NUM_W-1-k]};
		assign ge    = (trial >= {1'b0, denom});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && v_prev) begin
				rem_s[k] <= ge ? DEN_W'(trial - {1'b0, denom}) : trial[DEN_W-1:0];
				quo_s[k] <= ge ? (quo_prev | QBIT) : quo_prev;
				num_s[k] <= num_prev;
			end
		end
	end

	// The last stage is the output register.
	assign out_valid = v_s[NUM_W-1];
	assign numer_out = num_s[NUM_W-1];
	assign quotient  = quo_s[NUM_W-1];
	assign remainder = rem_s[NUM_W-1][NUM_W-1:0];

`ifndef NO_ASSERTIONS
	// Input side is only held off when every stage is occupied.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&full))
		else $error("divider refused a word with a free stage");

	// A finished remainder is below a non-zero divisor.
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[NUM_W-1] && denom != '0) |-> (rem_s[NUM_W-1] < denom))
		else $error("divider remainder not below divisor");
`endif

endmodule
